// ===== hw/rtl/gpioei_pkg.sv =====
package gpioei_pkg;

  localparam int unsigned PIN_COUNT = 32;
  localparam int unsigned DATA_W    = 32;

  localparam logic [DATA_W-1:0] PIN_MASK =
    DATA_W'((64'd1 << PIN_COUNT) - 64'd1);

  // request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register map
  localparam logic [3:0] REG_OUT    = 4'd0;
  localparam logic [3:0] REG_DIR    = 4'd1;
  localparam logic [3:0] REG_BLINK  = 4'd2;
  localparam logic [3:0] REG_POL    = 4'd3;
  localparam logic [3:0] REG_DATAIN = 4'd4;
  localparam logic [3:0] REG_CAUSE  = 4'd5;
  localparam logic [3:0] REG_EMASK  = 4'd6;
  localparam logic [3:0] REG_LMASK  = 4'd7;
  localparam logic [3:0] REG_ON     = 4'd8;
  localparam logic [3:0] REG_OFF    = 4'd9;

  typedef struct packed {
    logic              tick;
    logic [DATA_W-1:0] on_dur;
    logic [DATA_W-1:0] off_dur;
  } blink_ctl_t;

endpackage

// ===== hw/rtl/gpio_port_with_edge_level_irq_unit.sv =====
// 32-pin GPIO port with edge and level interrupts. Each transfer on the in_ channel is a
// register read, a register write or a pin-sample tick, and produces exactly one result
// on the out_ channel carrying the read data (zero unless a mapped read), the pin drive
// and enable vectors and the interrupt line, all as seen after that item's update.
// One item is taken every cycle; its result appears in the output register in the cycle
// after the transfer, and in_ready only drops while that register holds a result the
// consumer has not taken. A tick latches pins XOR polarity into data-in, sets edge-cause
// bits on rising edges and advances the shared blink timer.
module gpio_port_with_edge_level_irq_unit
  import gpioei_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [3:0]        in_reg_sel,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [DATA_W-1:0] in_pins_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data,
  output logic [DATA_W-1:0] out_pin_drive,
  output logic [DATA_W-1:0] out_pin_enable,
  output logic              out_irq_pending
);

  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic [DATA_W-1:0] dir_r, dir_nxt;
  logic [DATA_W-1:0] blink_r, blink_nxt;
  logic [DATA_W-1:0] pol_r, pol_nxt;
  logic [DATA_W-1:0] din_r, din_nxt;
  logic [DATA_W-1:0] cause_r, cause_nxt;
  logic [DATA_W-1:0] emask_r, emask_nxt;
  logic [DATA_W-1:0] lmask_r, lmask_nxt;
  logic [DATA_W-1:0] on_r, on_nxt;
  logic [DATA_W-1:0] off_r, off_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic [DATA_W-1:0] drive_r, drive_nxt;
  logic [DATA_W-1:0] oe_r, oe_nxt;
  logic              irq_r, irq_nxt;

  logic              accept;
  logic [DATA_W-1:0] fresh;
  logic [DATA_W-1:0] phase_bits;
  logic              phase_nxt;
  blink_ctl_t        blink_ctl;

  assign in_ready = ~ovalid_r | out_ready;
  assign accept   = in_valid & in_ready;

  assign blink_ctl.tick    = accept & (in_req_type == REQ_TICK);
  assign blink_ctl.on_dur  = on_r;
  assign blink_ctl.off_dur = off_r;

  gpioei_blink u_blink (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (blink_ctl),
    .phase_nxt (phase_nxt)
  );

  always_comb begin
    out_val_nxt = out_val_r;
    dir_nxt     = dir_r;
    blink_nxt   = blink_r;
    pol_nxt     = pol_r;
    din_nxt     = din_r;
    cause_nxt   = cause_r;
    emask_nxt   = emask_r;
    lmask_nxt   = lmask_r;
    on_nxt      = on_r;
    off_nxt     = off_r;
    rdata_nxt   = '0;
    fresh       = (in_pins_in ^ pol_r) & PIN_MASK;

    if (accept && in_req_type == REQ_READ) begin
      unique case (in_reg_sel)
        REG_OUT:    rdata_nxt = out_val_r;
        REG_DIR:    rdata_nxt = dir_r;
        REG_BLINK:  rdata_nxt = blink_r;
        REG_POL:    rdata_nxt = pol_r;
        REG_DATAIN: rdata_nxt = din_r;
        REG_CAUSE:  rdata_nxt = cause_r;
        REG_EMASK:  rdata_nxt = emask_r;
        REG_LMASK:  rdata_nxt = lmask_r;
        REG_ON:     rdata_nxt = on_r;
        REG_OFF:    rdata_nxt = off_r;
        default:    rdata_nxt = '0;
      endcase
    end

    if (accept && in_req_type == REQ_WRITE) begin
      unique case (in_reg_sel)
        REG_OUT:   out_val_nxt = in_write_data & PIN_MASK;
        REG_DIR:   dir_nxt     = in_write_data & PIN_MASK;
        REG_BLINK: blink_nxt   = in_write_data & PIN_MASK;
        REG_POL:   pol_nxt     = in_write_data & PIN_MASK;
        // write zero to clear
        REG_CAUSE: cause_nxt   = cause_r & in_write_data & PIN_MASK;
        REG_EMASK: emask_nxt   = in_write_data & PIN_MASK;
        REG_LMASK: lmask_nxt   = in_write_data & PIN_MASK;
        REG_ON:    on_nxt      = in_write_data;
        REG_OFF:   off_nxt     = in_write_data;
        default:   ;
      endcase
    end

    if (blink_ctl.tick) begin
      cause_nxt = cause_r | (fresh & ~din_r & PIN_MASK);
      din_nxt   = fresh;
    end

    phase_bits = {DATA_W{phase_nxt}};
    drive_nxt  = ((out_val_nxt & ~blink_nxt) | (blink_nxt & phase_bits)) & PIN_MASK;
    oe_nxt     = ~dir_nxt & PIN_MASK;
    irq_nxt    = (((din_nxt & lmask_nxt) | (cause_nxt & emask_nxt)) & PIN_MASK) != '0;
    ovalid_nxt = accept | (ovalid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_val_r <= '0;
      dir_r     <= PIN_MASK;
      blink_r   <= '0;
      pol_r     <= '0;
      din_r     <= '0;
      cause_r   <= '0;
      emask_r   <= '0;
      lmask_r   <= '0;
      on_r      <= DATA_W'(1);
      off_r     <= DATA_W'(1);
      ovalid_r  <= 1'b0;
    end else begin
      out_val_r <= out_val_nxt;
      dir_r     <= dir_nxt;
      blink_r   <= blink_nxt;
      pol_r     <= pol_nxt;
      din_r     <= din_nxt;
      cause_r   <= cause_nxt;
      emask_r   <= emask_nxt;
      lmask_r   <= lmask_nxt;
      on_r      <= on_nxt;
      off_r     <= off_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // result register, loaded on every transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= rdata_nxt;
      drive_r <= drive_nxt;
      oe_r    <= oe_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign out_valid       = ovalid_r;
  assign out_read_data   = rdata_r;
  assign out_pin_drive   = drive_r;
  assign out_pin_enable  = oe_r;
  assign out_irq_pending = irq_r;

endmodule

// ===== hw/rtl/gpioei_blink.sv =====
module gpioei_blink
  import gpioei_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  blink_ctl_t ctl,
  output logic       phase_nxt
);

  logic [DATA_W-1:0] count_r, count_nxt;
  logic              phase_r;
  logic [DATA_W-1:0] dur;
  logic [DATA_W-1:0] count_inc;

  always_comb begin
    dur = phase_r ? ctl.on_dur : ctl.off_dur;
    if (dur == '0) begin
      dur = DATA_W'(1);
    end
    // saturate at all ones
    count_inc = (count_r == '1) ? count_r : count_r + DATA_W'(1);
    count_nxt = count_r;
    phase_nxt = phase_r;
    if (ctl.tick) begin
      if (count_inc >= dur) begin
        count_nxt = '0;
        phase_nxt = ~phase_r;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= 1'b1;
    end else begin
      count_r <= count_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== hw/rtl/gpioei_chk.sv =====
module gpioei_chk
  import gpioei_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_req_type,
  input logic [3:0]        in_reg_sel,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_data
);

  // a result waiting to be taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

  // an empty output register never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  // every transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transfer produced no result");

  // only reads of mapped registers return data
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type != REQ_READ || in_reg_sel > REG_OFF)
    |=> out_read_data == '0)
    else $error("nonzero read data on a non-read or unmapped read");

endmodule

bind gpio_port_with_edge_level_irq_unit gpioei_chk u_gpioei_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_req_type   (in_req_type),
  .in_reg_sel    (in_reg_sel),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_data (out_read_data)
);

// ===== sim/gpio_port_with_edge_level_irq_unit_tb.sv =====
`timescale 1ns / 100ps

module gpio_port_with_edge_level_irq_unit_tb;
  import gpioei_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [3:0] REG_UNMAPPED = 4'd12;
  localparam int LONG_HOLD   = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] pin_drive;
    logic [DATA_W-1:0] pin_enable;
    logic              irq;
  } gpio_response_t;

  // Shadow copy of the port registers plus the queue of responses still owed.
  class gpio_shadow;
    logic [DATA_W-1:0] out_q, dir_q, blink_q, pol_q, din_q;
    logic [DATA_W-1:0] cause_q, emask_q, lmask_q, on_q, off_q, count_q;
    logic              phase_q;
    gpio_response_t    expected_responses[$];
    int                errors;

    function new();
      out_q   = '0;
      dir_q   = PIN_MASK;
      blink_q = '0;
      pol_q   = '0;
      din_q   = '0;
      cause_q = '0;
      emask_q = '0;
      lmask_q = '0;
      on_q    = 1;
      off_q   = 1;
      count_q = '0;
      phase_q = 1'b1;
      errors  = 0;
    endfunction

    function logic [DATA_W-1:0] read_register(logic [3:0] sel);
      case (sel)
        REG_OUT:    return out_q;
        REG_DIR:    return dir_q;
        REG_BLINK:  return blink_q;
        REG_POL:    return pol_q;
        REG_DATAIN: return din_q;
        REG_CAUSE:  return cause_q;
        REG_EMASK:  return emask_q;
        REG_LMASK:  return lmask_q;
        REG_ON:     return on_q;
        REG_OFF:    return off_q;
        default:    return '0;
      endcase
    endfunction

    function void write_register(logic [3:0] sel, logic [DATA_W-1:0] v);
      case (sel)
        REG_OUT:   out_q = v & PIN_MASK;
        REG_DIR:   dir_q = v & PIN_MASK;
        REG_BLINK: blink_q = v & PIN_MASK;
        REG_POL:   pol_q = v & PIN_MASK;
        REG_CAUSE: cause_q &= v & PIN_MASK; // write zero to clear
        REG_EMASK: emask_q = v & PIN_MASK;
        REG_LMASK: lmask_q = v & PIN_MASK;
        REG_ON:    on_q = v;
        REG_OFF:   off_q = v;
        default: ;
      endcase
    endfunction

    function void sample_pins(logic [DATA_W-1:0] pins);
      logic [DATA_W-1:0] fresh;
      logic [DATA_W-1:0] dur;
      fresh = (pins ^ pol_q) & PIN_MASK;
      dur = phase_q ? on_q : off_q;
      cause_q |= fresh & ~din_q & PIN_MASK;
      din_q = fresh;
      if (dur == '0) dur = 1;
      if (count_q != '1) count_q++;
      if (count_q >= dur) begin
        phase_q = ~phase_q;
        count_q = '0;
      end
    endfunction

    function void note_request(logic [1:0] req, logic [3:0] sel,
                               logic [DATA_W-1:0] wdata, logic [DATA_W-1:0] pins);
      gpio_response_t r;
      r = '0;
      case (req)
        REQ_READ:  r.read_data = read_register(sel);
        REQ_WRITE: write_register(sel, wdata);
        REQ_TICK:  sample_pins(pins);
        default: ;
      endcase
      r.pin_drive  = ((out_q & ~blink_q) | (blink_q & {DATA_W{phase_q}})) & PIN_MASK;
      r.pin_enable = ~dir_q & PIN_MASK;
      r.irq        = |(((din_q & lmask_q) | (cause_q & emask_q)) & PIN_MASK);
      expected_responses.push_back(r);
    endfunction

    task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_response(gpio_response_t got);
      gpio_response_t want;
      if (expected_responses.size() == 0) begin
        report("response with none pending, read_data", got.read_data, '0);
        return;
      end
      want = expected_responses.pop_front();
      if (got.read_data !== want.read_data)
        report("read_data", got.read_data, want.read_data);
      if (got.pin_drive !== want.pin_drive)
        report("pin_drive", got.pin_drive, want.pin_drive);
      if (got.pin_enable !== want.pin_enable)
        report("pin_enable", got.pin_enable, want.pin_enable);
      if (got.irq !== want.irq)
        report("irq_pending", DATA_W'(got.irq), DATA_W'(want.irq));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [3:0]        in_reg_sel;
  logic [DATA_W-1:0] in_write_data;
  logic [DATA_W-1:0] in_pins_in;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_read_data;
  logic [DATA_W-1:0] out_pin_drive;
  logic [DATA_W-1:0] out_pin_enable;
  logic              out_irq_pending;

  gpio_shadow        shadow;
  logic              idle_on;
  logic              hold_req;
  logic [DATA_W-1:0] last_pins;
  int unsigned       cycles;

  gpio_port_with_edge_level_irq_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_reg_sel     (in_reg_sel),
    .in_write_data  (in_write_data),
    .in_pins_in     (in_pins_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_pin_drive  (out_pin_drive),
    .out_pin_enable (out_pin_enable),
    .out_irq_pending(out_irq_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      shadow.check_response({out_read_data, out_pin_drive, out_pin_enable, out_irq_pending});
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        out_ready = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  // with in_valid still high.
  task automatic push_item(input logic [1:0] req, input logic [3:0] sel,
                           input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] pins);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_req_type   = req;
    in_reg_sel    = sel;
    in_write_data = wdata;
    in_pins_in    = pins;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(req, sel, wdata, pins);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int unsigned       k;
    logic [1:0]        req;
    logic [3:0]        sel;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] pins;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25)      req = REQ_READ;
      else if (k < 55) req = REQ_WRITE;
      else if (k < 95) req = REQ_TICK;
      else             req = REQ_UNUSED;
      if ($urandom_range(0, 9) == 0) sel = 4'($urandom_range(10, 15));
      else                           sel = 4'($urandom_range(0, 9));
      k = $urandom_range(0, 9);
      if (sel == REG_ON || sel == REG_OFF) begin
        // short durations keep the blink phase moving
        wdata = (k < 8) ? DATA_W'($urandom_range(0, 4)) : DATA_W'($urandom);
      end else begin
        wdata = (k == 0) ? '0 : (k == 1) ? '1 : DATA_W'($urandom);
      end
      k = $urandom_range(0, 9);
      if (k < 6)       pins = $urandom;
      else if (k == 6) pins = '0;
      else if (k == 7) pins = '1;
      else             pins = last_pins ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
      if (req == REQ_TICK) last_pins = pins;
      push_item(req, sel, wdata, pins);
    end
  endtask

  initial begin
    shadow        = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_READ;
    in_reg_sel    = REG_OUT;
    in_write_data = '0;
    in_pins_in    = '0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    last_pins     = '0;
    cycles        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values of every register
    for (int r = 0; r < 10; r++)
      push_item(REQ_READ, 4'(r), '0, '0);
    push_item(REQ_WRITE, REG_DATAIN, '1, '0);  // read only, must be ignored
    push_item(REQ_WRITE, REG_OUT, '1, '0);
    push_item(REQ_WRITE, REG_DIR, '0, '0);
    push_item(REQ_WRITE, REG_BLINK, 32'h0000_ffff, '0);
    push_item(REQ_WRITE, REG_ON, '0, '0);       // zero duration acts as one
    push_item(REQ_WRITE, REG_OFF, 32'd2, '0);
    push_item(REQ_TICK, REG_OUT, '0, '1);       // rising edge on every pin
    push_item(REQ_WRITE, REG_EMASK, '1, '0);
    push_item(REQ_WRITE, REG_POL, '1, '0);
    push_item(REQ_TICK, REG_OUT, '0, '1);       // inverted: data-in drops
    push_item(REQ_WRITE, REG_LMASK, '1, '0);
    push_item(REQ_TICK, REG_OUT, '0, '0);
    push_item(REQ_WRITE, REG_CAUSE, 32'h0f0f_0f0f, '0);
    push_item(REQ_WRITE, REG_UNMAPPED, '1, '0);
    push_item(REQ_UNUSED, REG_OUT, '1, '1);
    push_item(REQ_READ, REG_UNMAPPED, '0, '0);

    run_random(700);

    // stall the result side long enough for the input to back up
    hold_req = 1'b1;
    run_random(40);

    // let everything drain before going on
    in_valid = 1'b0;
    while (shadow.expected_responses.size() != 0) @(negedge clk);

    run_random(560);

    idle_on = 1'b0;
    run_random(250);
    in_valid = 1'b0;

    while (shadow.expected_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (shadow.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
